[rtl/pqd_pkg.sv]
// ----------------------------------------------------------------------------
// pqd_pkg
// Shared constants, types and the arctangent table of the planar quadrotor
// dynamics block.
// ----------------------------------------------------------------------------
package pqd_pkg;

  localparam int TrigStages = 16;
  localparam int AtanEntries = 24;
  localparam int StageW = $clog2(AtanEntries);

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [31:0] HalfPi = 32'sd105414357;
  localparam logic signed [31:0] FullPi = 32'sd210828714;

  localparam logic [2:0] RegThrustGain = 3'd0;
  localparam logic [2:0] RegTorqueGain = 3'd1;
  localparam logic [2:0] RegGravity = 3'd2;
  localparam logic [2:0] RegDragEn = 3'd3;
  localparam logic [2:0] RegLinDrag = 3'd4;
  localparam logic [2:0] RegAngDrag = 3'd5;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] w;
    logic [15:0] t1;
    logic [15:0] t2;
    logic flip;
  } pqd_pay_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] z;
  } pqd_vec_t;

  function automatic logic [31:0] atan_q26(input logic [StageW-1:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd52707179;
        5'd1: r = 32'd31114864;
        5'd2: r = 32'd16440240;
        5'd3: r = 32'd8345322;
        5'd4: r = 32'd4188855;
        5'd5: r = 32'd2096470;
        5'd6: r = 32'd1048491;
        5'd7: r = 32'd524277;
        5'd8: r = 32'd262143;
        default: r = 32'd1 << (5'd26 - i);
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [23:0] sat_round(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = (v + 64'sd134217728) >>> 28;
      if (r > 64'sd8388607) return 24'sh7fffff;
      if (r < -64'sd8388608) return 24'sh800000;
      return r[23:0];
    end
  endfunction

endpackage

[rtl/pqd_cell.sv]
// ----------------------------------------------------------------------------
// pqd_cell
// One CORDIC rotation cell with its payload register.
// ----------------------------------------------------------------------------
module pqd_cell import pqd_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [StageW-1:0] idx,
  input  pqd_vec_t          vec_i,
  input  pqd_pay_t          pay_i,
  output pqd_vec_t          vec_o,
  output pqd_pay_t          pay_o
);

  pqd_vec_t vec_r, vec_nxt;
  pqd_pay_t pay_r;

  always_comb begin
    if (!vec_i.z[31]) begin
      vec_nxt.x = vec_i.x - (vec_i.y >>> idx);
      vec_nxt.y = vec_i.y + (vec_i.x >>> idx);
      vec_nxt.z = vec_i.z - $signed(atan_q26(idx));
    end else begin
      vec_nxt.x = vec_i.x + (vec_i.y >>> idx);
      vec_nxt.y = vec_i.y - (vec_i.x >>> idx);
      vec_nxt.z = vec_i.z + $signed(atan_q26(idx));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
      pay_r <= pay_i;
    end
  end

  assign vec_o = vec_r;
  assign pay_o = pay_r;

endmodule

[rtl/pqd_accel.sv]
// ----------------------------------------------------------------------------
// pqd_accel
// Rounds sine and cosine and forms the three accelerations over three stages.
// ----------------------------------------------------------------------------
module pqd_accel import pqd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  pqd_vec_t           vec_i,
  input  pqd_pay_t           pay_i,
  input  logic [15:0]        thrust_gain,
  input  logic [15:0]        torque_gain,
  input  logic [15:0]        gravity,
  input  logic               drag_en,
  input  logic [15:0]        lin_drag,
  input  logic [15:0]        ang_drag,
  output pqd_pay_t           pay_o,
  output logic signed [23:0] ax_o,
  output logic signed [23:0] ay_o,
  output logic signed [23:0] aw_o
);

  logic signed [19:0] sn, cs;
  logic signed [33:0] xr, yr;
  pqd_pay_t p1_r, p2_r, p3_r;
  logic signed [19:0] sn_r, cs_r;
  logic signed [34:0] force_r;
  logic signed [34:0] torq_r;
  logic signed [33:0] dx_r, dy_r, dw_r;
  logic signed [55:0] fs_r, fc_r;
  logic signed [23:0] ax_r, ay_r, aw_r;
  logic signed [63:0] sx, sy, sw;

  always_comb begin
    xr = (vec_i.x + 34'sd32768) >>> 16;
    yr = (vec_i.y + 34'sd32768) >>> 16;
    cs = pay_i.flip ? -xr[19:0] : xr[19:0];
    sn = pay_i.flip ? -yr[19:0] : yr[19:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= pay_i;
      sn_r <= sn;
      cs_r <= cs;
      force_r <= $signed({1'b0, 17'(pay_i.t1) + 17'(pay_i.t2)}) * $signed({19'd0, thrust_gain});
      torq_r <= $signed(35'($signed({1'b0, pay_i.t1}) - $signed({1'b0, pay_i.t2})))
        * $signed({19'd0, torque_gain});
      dx_r <= drag_en ? $signed({1'b0, lin_drag}) * pay_i.vx : 34'sd0;
      dy_r <= drag_en ? $signed({1'b0, lin_drag}) * pay_i.vy : 34'sd0;
      dw_r <= drag_en ? $signed({1'b0, ang_drag}) * pay_i.w : 34'sd0;
      p2_r <= p1_r;
      fs_r <= force_r * sn_r;
      fc_r <= force_r * cs_r;
      p3_r <= p2_r;
      ax_r <= sat_round(sx);
      ay_r <= sat_round(sy);
      aw_r <= sat_round(sw);
    end
  end

  logic signed [34:0] torq_d_r;
  logic signed [33:0] dx_d_r, dy_d_r, dw_d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      torq_d_r <= torq_r;
      dx_d_r <= dx_r;
      dy_d_r <= dy_r;
      dw_d_r <= dw_r;
    end
  end

  always_comb begin
    sx = -64'(fs_r) - (64'(dx_d_r) <<< 20);
    sy = 64'(fc_r) - (64'($signed({1'b0, gravity})) <<< 28) - (64'(dy_d_r) <<< 20);
    sw = (64'(torq_d_r) <<< 14) - (64'(dw_d_r) <<< 20);
  end

  assign pay_o = p3_r;
  assign ax_o = ax_r;
  assign ay_o = ay_r;
  assign aw_o = aw_r;

endmodule

[rtl/planar_quadrotor_dynamics.sv]
// ----------------------------------------------------------------------------
// planar_quadrotor_dynamics
// State derivative of a planar two-rotor vehicle, CORDIC chain and gains.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake
// in_      in   in_valid / in_ready
// out_     out  out_valid / out_ready
// APB      both APB write and read, pready tied high
// Requests pass the CORDIC cells, then pqd_accel; one request per cycle is accepted while out_ready is not stalling.
// The whole pipe advances when the last stage is empty or being taken.
// A stall at the output holds every stage in place.
// Reset clears the valid bits and loads the register reset values.
module planar_quadrotor_dynamics import pqd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_yaw_angle,
  input  logic signed [15:0] in_x_velocity,
  input  logic signed [15:0] in_y_velocity,
  input  logic signed [15:0] in_yaw_rate,
  input  logic [15:0]        in_thrust_first,
  input  logic [15:0]        in_thrust_second,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x_rate,
  output logic signed [15:0] out_y_rate,
  output logic signed [15:0] out_angle_rate,
  output logic signed [23:0] out_x_accel,
  output logic signed [23:0] out_y_accel,
  output logic signed [23:0] out_angular_accel,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int Depth = TrigStages + 3;

  logic [15:0] tg_r, qg_r, gr_r, ld_r, ad_r;
  logic de_r;
  logic [Depth-1:0] vld_r;
  logic en;
  logic [2:0] ra;

  assign pready = 1'b1;
  assign ra = paddr[4:2];
  assign en = !vld_r[Depth-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tg_r <= 16'd1256;
      qg_r <= 16'd0;
      gr_r <= 16'd2511;
      de_r <= 1'b0;
      ld_r <= 16'd0;
      ad_r <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (ra)
        RegThrustGain: tg_r <= pwdata[15:0];
        RegTorqueGain: qg_r <= pwdata[15:0];
        RegGravity: gr_r <= pwdata[15:0];
        RegDragEn: de_r <= pwdata[0];
        RegLinDrag: ld_r <= pwdata[15:0];
        RegAngDrag: ad_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ra)
      RegThrustGain: prdata = {16'd0, tg_r};
      RegTorqueGain: prdata = {16'd0, qg_r};
      RegGravity: prdata = {16'd0, gr_r};
      RegDragEn: prdata = {31'd0, de_r};
      RegLinDrag: prdata = {16'd0, ld_r};
      RegAngDrag: prdata = {16'd0, ad_r};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Depth-2:0], in_valid};
  end

  pqd_vec_t vec [TrigStages+1];
  pqd_pay_t pay [TrigStages+1];
  pqd_vec_t vec_in;
  pqd_pay_t pay_in;
  logic signed [31:0] z0;

  always_comb begin
    z0 = 32'(in_yaw_angle) <<< 13;
    pay_in = '{in_x_velocity, in_y_velocity, in_yaw_rate,
               in_thrust_first, in_thrust_second, 1'b0};
    if (z0 > HalfPi) begin
      z0 = z0 - FullPi;
      pay_in.flip = 1'b1;
    end else if (z0 < -HalfPi) begin
      z0 = z0 + FullPi;
      pay_in.flip = 1'b1;
    end
    vec_in = '{CordicGain, 34'sd0, z0};
  end

  assign vec[0] = vec_in;
  assign pay[0] = pay_in;

  for (genvar g = 0; g < TrigStages; g++) begin : g_cell
    pqd_cell u_cell (
      .clk(clk), .en(en), .idx(StageW'(g)), .vec_i(vec[g]), .pay_i(pay[g]),
      .vec_o(vec[g+1]), .pay_o(pay[g+1])
    );
  end

  pqd_pay_t pay_o;
  pqd_accel u_accel (
    .clk(clk), .en(en), .vec_i(vec[TrigStages]), .pay_i(pay[TrigStages]),
    .thrust_gain(tg_r), .torque_gain(qg_r), .gravity(gr_r), .drag_en(de_r),
    .lin_drag(ld_r), .ang_drag(ad_r), .pay_o(pay_o),
    .ax_o(out_x_accel), .ay_o(out_y_accel), .aw_o(out_angular_accel)
  );

  assign out_valid = vld_r[Depth-1];
  assign out_x_rate = pay_o.vx;
  assign out_y_rate = pay_o.vy;
  assign out_angle_rate = pay_o.w;

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("lost result");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("false stall");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0]) else $error("request dropped");

endmodule
